// File: rtl/hncd_pkg.sv
// Shared types and constants of the hotkey numeric command decoder.
// Used by hncd_front, hncd_queue, hncd_back and the top level; no dependencies.
`default_nettype none

package hncd_pkg;

   // default storage widths of the id and delay accumulators
   localparam int ID_BITS_DEF    = 22;
   localparam int DELAY_BITS_DEF = 32;

   // fixed payload widths
   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 1;
   localparam int TARGET_W   = 22;
   localparam int DELAY_W    = 32;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = 2;

   // decoupling queue depth
   localparam int Q_DEPTH = 2;

   // set-1 key codes (bits 6..0 of a scancode)
   localparam logic [6:0] KEY_CTRL  = 7'h1D;
   localparam logic [6:0] KEY_ALT   = 7'h38;
   localparam logic [6:0] KEY_SPACE = 7'h39;
   localparam logic [6:0] KEY_SEC   = 7'h1F;
   localparam logic [6:0] KEY_MIN   = 7'h32;
   localparam logic [6:0] KEY_HOUR  = 7'h23;
   localparam logic [6:0] KEY_DIG1  = 7'h02;
   localparam logic [6:0] KEY_DIG0  = 7'h0B;

   // time units: seconds, minutes, hours in milliseconds
   localparam int N_UNITS = 3;
   localparam int UNIT_W  = $clog2(N_UNITS);
   localparam int SCALE_W = 22;
   localparam logic [UNIT_W-1:0] UNIT_SEC  = 2'd0;
   localparam logic [UNIT_W-1:0] UNIT_MIN  = 2'd1;
   localparam logic [UNIT_W-1:0] UNIT_HOUR = 2'd2;
   localparam logic [SCALE_W-1:0] MS_SCALE [N_UNITS] = '{22'd1000, 22'd60000, 22'd3600000};

   // digit times scale fits in this many bits (9 * 3600000 < 2^25)
   localparam int DSCALE_W = 26;

   typedef enum logic [2:0] {
      KC_OTHER,
      KC_CTRL,
      KC_ALT,
      KC_SPACE,
      KC_DIGIT,
      KC_UNIT
   } key_class_type;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_ID,
      MODE_DELAY
   } mode_type;

   typedef enum logic [1:0] {
      ACT_KILL  = 2'd0,
      ACT_ARM   = 2'd1,
      ACT_TIMED = 2'd2
   } action_type;

   // classified item passed from the front end to the back end
   typedef struct packed {
      logic                expiry;
      logic                make;
      key_class_type       kind;
      logic [3:0]          digit;
      logic [UNIT_W-1:0]   unit;
   } item_type;

endpackage

`default_nettype wire

// File: rtl/hncd_front.sv
// Front end: accepts request transfers and classifies each scancode.
// Depends on hncd_pkg.
`default_nettype none

module hncd_front (
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   input  wire logic [hncd_pkg::REQ_USER_W-1:0]    req_tuser,  // [0] op
   input  wire logic [hncd_pkg::REQ_DATA_W-1:0]    req_tdata,  // [7:0] scan_byte
   input  wire logic                               q_full,
   output      logic                               wr_en,
   output      hncd_pkg::item_type                 wr_item
);

   logic [6:0] key;

   assign key        = req_tdata[6:0];
   assign req_tready = ~q_full;
   assign wr_en      = req_tvalid & ~q_full;

   always_comb begin
      wr_item        = '0;
      wr_item.expiry = req_tuser[0];
      wr_item.make   = ~req_tdata[7];
      wr_item.kind   = hncd_pkg::KC_OTHER;
      wr_item.digit  = 4'd0;
      wr_item.unit   = hncd_pkg::UNIT_SEC;
      if (key inside {[hncd_pkg::KEY_DIG1:hncd_pkg::KEY_DIG0]}) begin
         wr_item.kind = hncd_pkg::KC_DIGIT;
         // keys 1..9 sit one above their value; the zero key comes last
         if (key == hncd_pkg::KEY_DIG0) begin
            wr_item.digit = 4'd0;
         end else begin
            wr_item.digit = 4'(key - 7'd1);
         end
      end else begin
         case (key)
            hncd_pkg::KEY_CTRL:  wr_item.kind = hncd_pkg::KC_CTRL;
            hncd_pkg::KEY_ALT:   wr_item.kind = hncd_pkg::KC_ALT;
            hncd_pkg::KEY_SPACE: wr_item.kind = hncd_pkg::KC_SPACE;
            hncd_pkg::KEY_SEC: begin
               wr_item.kind = hncd_pkg::KC_UNIT;
               wr_item.unit = hncd_pkg::UNIT_SEC;
            end
            hncd_pkg::KEY_MIN: begin
               wr_item.kind = hncd_pkg::KC_UNIT;
               wr_item.unit = hncd_pkg::UNIT_MIN;
            end
            hncd_pkg::KEY_HOUR: begin
               wr_item.kind = hncd_pkg::KC_UNIT;
               wr_item.unit = hncd_pkg::UNIT_HOUR;
            end
            default: wr_item.kind = hncd_pkg::KC_OTHER;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: rtl/hncd_queue.sv
// Short FIFO of classified items between the front end and the back end.
// Depends on hncd_pkg.
`default_nettype none

module hncd_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr_en,
   input  wire hncd_pkg::item_type  wr_item,
   input  wire logic                rd_en,
   output      hncd_pkg::item_type  rd_item,
   output      logic                rd_valid,
   output      logic                full
);

   localparam int PTR_W = $clog2(hncd_pkg::Q_DEPTH);
   localparam int CNT_W = $clog2(hncd_pkg::Q_DEPTH + 1);

   hncd_pkg::item_type  entry_ff [hncd_pkg::Q_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign rd_item  = entry_ff[rd_ptr_ff];
   assign rd_valid = (count_ff != '0);
   assign full     = (count_ff == CNT_W'(hncd_pkg::Q_DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(hncd_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(hncd_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

`default_nettype wire

// File: rtl/hncd_back.sv
// Back end: hotkey mode tracking, id and delay accumulation, command issue
// and the result output register. Depends on hncd_pkg.
`default_nettype none

module hncd_back #(
   parameter int ID_BITS    = hncd_pkg::ID_BITS_DEF,
   parameter int DELAY_BITS = hncd_pkg::DELAY_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               q_valid,
   input  wire hncd_pkg::item_type                 q_item,
   output      logic                               q_pop,
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   output      logic [hncd_pkg::RSP_USER_W-1:0]    rsp_tuser,  // [1:0] action
   output      logic [hncd_pkg::RSP_DATA_W-1:0]    rsp_tdata   // [21:0] target_id,
                                                               // [53:22] delay_ms, zero pad
);

   localparam int ID_WIDE = ID_BITS + 4;
   localparam int DL_WIDE = DELAY_BITS + hncd_pkg::DSCALE_W;
   localparam int SUM_W   = DELAY_BITS + 1;
   localparam logic [ID_BITS-1:0]    ID_MAX    = '1;
   localparam logic [DELAY_BITS-1:0] DELAY_MAX = '1;

   hncd_pkg::mode_type      mode_ff, mode_in;
   logic                    ctrl_ff, ctrl_in;
   logic                    alt_ff, alt_in;
   logic                    space_ff, space_in;
   logic                    armed_ff, armed_in;
   logic [ID_BITS-1:0]      id_ff, id_in;
   logic [DELAY_BITS-1:0]   delay_ff, delay_in;
   logic [ID_BITS-1:0]      last_ff, last_in;
   // pending digit count already scaled by each unit, with a flag once it
   // passes the delay maximum
   logic [DELAY_BITS-1:0]   scaled_ff [hncd_pkg::N_UNITS];
   logic [DELAY_BITS-1:0]   scaled_in [hncd_pkg::N_UNITS];
   logic [hncd_pkg::N_UNITS-1:0] over_ff, over_in;

   logic                    out_valid_ff;
   hncd_pkg::action_type    out_action_ff;
   logic [hncd_pkg::TARGET_W-1:0] out_target_ff;
   logic [hncd_pkg::DELAY_W-1:0]  out_delay_ff;

   logic                    step, scan, expire;
   logic [ID_WIDE-1:0]      id_push;
   logic [ID_BITS-1:0]      id_upd;
   logic [DELAY_BITS-1:0]   delay_upd;
   logic [hncd_pkg::DSCALE_W-1:0] dscale [hncd_pkg::N_UNITS];
   logic [DL_WIDE-1:0]      lane_push [hncd_pkg::N_UNITS];
   logic [SUM_W-1:0]        lane_sum [hncd_pkg::N_UNITS];
   logic [SUM_W-1:0]        sel_sum;
   logic                    sel_over;
   logic                    chord, released;
   logic                    fire_kill, fire_arm;
   logic                    res_valid;
   hncd_pkg::action_type    res_action;
   logic [ID_BITS-1:0]      res_id;
   logic [ID_BITS+hncd_pkg::TARGET_W-1:0]   res_id_ext;
   logic [DELAY_BITS+hncd_pkg::DELAY_W-1:0] res_delay_ext;

   assign step   = q_valid & (~out_valid_ff | rsp_tready);
   assign q_pop  = step;
   assign scan   = step & ~q_item.expiry;
   assign expire = step & q_item.expiry;

   // one lane per time unit: scaled*10 + digit*scale, and delay + scaled
   always_comb begin
      for (int u = 0; u < hncd_pkg::N_UNITS; u++) begin
         dscale[u]    = hncd_pkg::DSCALE_W'(q_item.digit)
                        * hncd_pkg::DSCALE_W'(hncd_pkg::MS_SCALE[u]);
         lane_push[u] = DL_WIDE'({scaled_ff[u], 3'b000}) + DL_WIDE'({scaled_ff[u], 1'b0})
                        + DL_WIDE'(dscale[u]);
         lane_sum[u]  = SUM_W'(delay_ff) + SUM_W'(scaled_ff[u]);
      end
   end

   always_comb begin
      case (q_item.unit)
         hncd_pkg::UNIT_SEC: begin
            sel_sum  = lane_sum[0];
            sel_over = over_ff[0];
         end
         hncd_pkg::UNIT_MIN: begin
            sel_sum  = lane_sum[1];
            sel_over = over_ff[1];
         end
         hncd_pkg::UNIT_HOUR: begin
            sel_sum  = lane_sum[2];
            sel_over = over_ff[2];
         end
         default: begin
            sel_sum  = lane_sum[0];
            sel_over = over_ff[0];
         end
      endcase
   end

   assign id_push = ID_WIDE'({id_ff, 3'b000}) + ID_WIDE'({id_ff, 1'b0})
                    + ID_WIDE'(q_item.digit);

   // held keys, digit and unit accumulation
   always_comb begin
      ctrl_in   = ctrl_ff;
      alt_in    = alt_ff;
      space_in  = space_ff;
      id_upd    = id_ff;
      delay_upd = delay_ff;
      scaled_in = scaled_ff;
      over_in   = over_ff;
      if (scan) begin
         case (q_item.kind)
            hncd_pkg::KC_CTRL:  ctrl_in  = q_item.make;
            hncd_pkg::KC_ALT:   alt_in   = q_item.make;
            hncd_pkg::KC_SPACE: space_in = q_item.make;
            default: ;
         endcase
         if (q_item.make && mode_ff == hncd_pkg::MODE_ID
             && q_item.kind == hncd_pkg::KC_DIGIT) begin
            id_upd = (id_push > ID_WIDE'(ID_MAX)) ? ID_MAX : id_push[ID_BITS-1:0];
         end
         if (q_item.make && mode_ff == hncd_pkg::MODE_DELAY) begin
            if (q_item.kind == hncd_pkg::KC_DIGIT) begin
               for (int u = 0; u < hncd_pkg::N_UNITS; u++) begin
                  scaled_in[u] = lane_push[u][DELAY_BITS-1:0];
                  over_in[u]   = over_ff[u] | (lane_push[u] > DL_WIDE'(DELAY_MAX));
               end
            end else if (q_item.kind == hncd_pkg::KC_UNIT) begin
               if (sel_over || sel_sum > SUM_W'(DELAY_MAX)) begin
                  delay_upd = DELAY_MAX;
               end else begin
                  delay_upd = sel_sum[DELAY_BITS-1:0];
               end
               for (int u = 0; u < hncd_pkg::N_UNITS; u++) begin
                  scaled_in[u] = '0;
               end
               over_in = '0;
            end
         end
      end
   end

   assign chord     = ctrl_in & alt_in;
   assign released  = ~ctrl_in & ~alt_in;
   assign fire_kill = scan && mode_ff == hncd_pkg::MODE_ID && released && id_upd != '0;
   assign fire_arm  = scan && mode_ff == hncd_pkg::MODE_DELAY && released
                      && id_upd != '0 && delay_upd != '0 && !armed_ff;

   // entry mode next state
   always_comb begin
      mode_in = mode_ff;
      if (scan) begin
         case (mode_ff)
            hncd_pkg::MODE_IDLE: begin
               // Space already held: id entry passes straight on to delay entry
               if (chord && space_in) begin
                  mode_in = hncd_pkg::MODE_DELAY;
               end else if (chord) begin
                  mode_in = hncd_pkg::MODE_ID;
               end
            end
            hncd_pkg::MODE_ID: begin
               if (chord && space_in) begin
                  mode_in = hncd_pkg::MODE_DELAY;
               end else if (fire_kill) begin
                  mode_in = hncd_pkg::MODE_IDLE;
               end
            end
            hncd_pkg::MODE_DELAY: begin
               if (fire_arm) begin
                  mode_in = hncd_pkg::MODE_IDLE;
               end
            end
            default: mode_in = hncd_pkg::MODE_IDLE;
         endcase
      end
   end

   // commands, accumulator clearing and results
   always_comb begin
      id_in      = id_upd;
      delay_in   = delay_upd;
      last_in    = last_ff;
      armed_in   = armed_ff;
      res_valid  = 1'b0;
      res_action = hncd_pkg::ACT_KILL;
      res_id     = last_ff;
      if (expire && armed_ff) begin
         armed_in   = 1'b0;
         res_valid  = 1'b1;
         res_action = hncd_pkg::ACT_TIMED;
      end
      if (fire_kill || fire_arm) begin
         last_in    = id_upd;
         res_id     = id_upd;
         res_valid  = 1'b1;
         res_action = fire_arm ? hncd_pkg::ACT_ARM : hncd_pkg::ACT_KILL;
         if (fire_arm) begin
            armed_in = 1'b1;
         end
      end
      // with no entry mode and both modifiers up the accumulators restart
      if (scan && mode_in == hncd_pkg::MODE_IDLE && released) begin
         id_in    = '0;
         delay_in = '0;
      end
   end

   assign res_id_ext    = {{hncd_pkg::TARGET_W{1'b0}}, res_id};
   assign res_delay_ext = {{hncd_pkg::DELAY_W{1'b0}},
                           (fire_arm ? delay_upd : {DELAY_BITS{1'b0}})};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= hncd_pkg::MODE_IDLE;
         ctrl_ff  <= 1'b0;
         alt_ff   <= 1'b0;
         space_ff <= 1'b0;
         armed_ff <= 1'b0;
         id_ff    <= '0;
         delay_ff <= '0;
         last_ff  <= '0;
         over_ff  <= '0;
         for (int u = 0; u < hncd_pkg::N_UNITS; u++) begin
            scaled_ff[u] <= '0;
         end
      end else begin
         mode_ff   <= mode_in;
         ctrl_ff   <= ctrl_in;
         alt_ff    <= alt_in;
         space_ff  <= space_in;
         armed_ff  <= armed_in;
         id_ff     <= id_in;
         delay_ff  <= delay_in;
         last_ff   <= last_in;
         over_ff   <= over_in;
         scaled_ff <= scaled_in;
      end
   end

   // output register; res_valid only rises when the slot is free or draining
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (res_valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         out_action_ff <= res_action;
         out_target_ff <= res_id_ext[hncd_pkg::TARGET_W-1:0];
         out_delay_ff  <= res_delay_ext[hncd_pkg::DELAY_W-1:0];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_action_ff;
   assign rsp_tdata  = {{(hncd_pkg::RSP_DATA_W - hncd_pkg::DELAY_W - hncd_pkg::TARGET_W){1'b0}},
                        out_delay_ff, out_target_ff};

endmodule

`default_nettype wire

// File: rtl/hotkey_numeric_command_decoder.sv
// Hotkey numeric command decoder, top level.
// Request side: one transfer per set-1 scancode byte (tuser = 0) or per
// timer expiry (tuser = 1); bit 7 of the byte marks a key release.
// Response side: at most one command per request: kill now, arm timer with
// a millisecond delay, or timed kill of the last target on expiry.
// Ctrl+Alt held starts id entry (digits build a decimal id); adding Space
// switches to delay entry (digits followed by s, m or h add to the delay).
// Releasing Ctrl and Alt issues the command.
// Throughput: one request per cycle while rsp_tready does not stall the output. A request is
// decoded in the front end, waits in a two-entry queue and is executed by the back end;
// its command is registered in the output register, which drives rsp_.
// When rsp_tready is low the output register holds its command, the back end
// stops, the queue fills and req_tready drops once it is full; the front end
// keeps taking requests until then.
// Reset (synchronous, active high) clears held keys, entry mode, the
// accumulators, the armed flag, the queue and the output valid.
// Depends on hncd_pkg, hncd_front, hncd_queue, hncd_back.
`default_nettype none

module hotkey_numeric_command_decoder #(
   parameter int ID_BITS    = hncd_pkg::ID_BITS_DEF,
   parameter int DELAY_BITS = hncd_pkg::DELAY_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   input  wire logic [hncd_pkg::REQ_USER_W-1:0]    req_tuser,  // [0] op
   input  wire logic [hncd_pkg::REQ_DATA_W-1:0]    req_tdata,  // [7:0] scan_byte
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   output      logic [hncd_pkg::RSP_USER_W-1:0]    rsp_tuser,  // [1:0] action
   output      logic [hncd_pkg::RSP_DATA_W-1:0]    rsp_tdata   // [21:0] target_id,
                                                               // [53:22] delay_ms, zero pad
);

   logic                q_full;
   logic                q_wr_en;
   hncd_pkg::item_type  q_wr_item;
   logic                q_rd_en;
   hncd_pkg::item_type  q_rd_item;
   logic                q_rd_valid;

   hncd_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .wr_en      (q_wr_en),
      .wr_item    (q_wr_item)
   );

   hncd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_wr_en),
      .wr_item  (q_wr_item),
      .rd_en    (q_rd_en),
      .rd_item  (q_rd_item),
      .rd_valid (q_rd_valid),
      .full     (q_full)
   );

   hncd_back #(
      .ID_BITS    (ID_BITS),
      .DELAY_BITS (DELAY_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_rd_valid),
      .q_item     (q_rd_item),
      .q_pop      (q_rd_en),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: tb/hotkey_numeric_command_decoder_test.sv
// Self-checking testbench for hotkey_numeric_command_decoder: scancode and expiry
// transfers in, kill/arm/timed-kill commands out, checked against a command predictor.
// Depends on hncd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module hotkey_numeric_command_decoder_test;

   localparam bit OP_SCAN   = 1'b0;
   localparam bit OP_EXPIRY = 1'b1;
   localparam logic [7:0] RELEASE_BIT = 8'h80;
   localparam longint unsigned ID_MAX    = (64'd1 << hncd_pkg::ID_BITS_DEF) - 1;
   localparam longint unsigned DELAY_MAX = (64'd1 << hncd_pkg::DELAY_BITS_DEF) - 1;
   localparam int RANDOM_ITEMS   = 1250;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 20;

   typedef struct {
      hncd_pkg::action_type             action;
      logic [hncd_pkg::TARGET_W-1:0]    target;
      logic [hncd_pkg::DELAY_W-1:0]     delay;
   } command_type;

   class command_scoreboard;
      bit ctrl_down, alt_down, space_down, armed;
      hncd_pkg::mode_type mode;
      longint unsigned id_acc, digit_count, delay_acc, last_id;
      command_type expected[$];
      int errors;

      function longint unsigned push_decimal(longint unsigned acc, longint unsigned d,
                                             longint unsigned limit);
         if (acc > (limit - d) / 10)
            return limit;
         return acc * 10 + d;
      endfunction

      function void issue(hncd_pkg::action_type act, longint unsigned dly);
         command_type cmd;
         cmd.action = act;
         cmd.target = last_id[hncd_pkg::TARGET_W-1:0];
         cmd.delay  = dly[hncd_pkg::DELAY_W-1:0];
         expected.push_back(cmd);
      endfunction

      // Advance the decoder state by one accepted request transfer.
      function void note_request(bit op, logic [7:0] scan);
         logic [6:0] key;
         bit make;
         int digit;
         longint unsigned mult;
         key  = scan[6:0];
         make = (scan & RELEASE_BIT) == 0;
         if (op == OP_EXPIRY) begin
            if (armed) begin
               armed = 0;
               issue(hncd_pkg::ACT_TIMED, 0);
            end
            return;
         end
         if (key == hncd_pkg::KEY_CTRL) ctrl_down = make;
         if (key == hncd_pkg::KEY_ALT) alt_down = make;
         if (key == hncd_pkg::KEY_SPACE) space_down = make;
         digit = -1;
         if (key >= hncd_pkg::KEY_DIG1 && key < hncd_pkg::KEY_DIG0)
            digit = int'(key - hncd_pkg::KEY_DIG1) + 1;
         else if (key == hncd_pkg::KEY_DIG0)
            digit = 0;

         if (make && mode == hncd_pkg::MODE_ID && digit >= 0)
            id_acc = push_decimal(id_acc, digit, ID_MAX);
         if (make && mode == hncd_pkg::MODE_DELAY) begin
            if (digit >= 0) begin
               digit_count = push_decimal(digit_count, digit, DELAY_MAX);
            end else if (key == hncd_pkg::KEY_SEC || key == hncd_pkg::KEY_MIN ||
                         key == hncd_pkg::KEY_HOUR) begin
               mult = key == hncd_pkg::KEY_SEC ? hncd_pkg::MS_SCALE[hncd_pkg::UNIT_SEC] :
                      key == hncd_pkg::KEY_MIN ? hncd_pkg::MS_SCALE[hncd_pkg::UNIT_MIN] :
                                                 hncd_pkg::MS_SCALE[hncd_pkg::UNIT_HOUR];
               if (digit_count > DELAY_MAX / mult)
                  delay_acc = DELAY_MAX;
               else if (digit_count * mult > DELAY_MAX - delay_acc)
                  delay_acc = DELAY_MAX;
               else
                  delay_acc += digit_count * mult;
               digit_count = 0;
            end
         end

         if (mode == hncd_pkg::MODE_IDLE && ctrl_down && alt_down)
            mode = hncd_pkg::MODE_ID;
         if (mode == hncd_pkg::MODE_ID && ctrl_down && alt_down && space_down)
            mode = hncd_pkg::MODE_DELAY;

         // zero id or zero delay keeps the entry mode open
         if (mode == hncd_pkg::MODE_ID && !ctrl_down && !alt_down && id_acc != 0) begin
            last_id = id_acc;
            issue(hncd_pkg::ACT_KILL, 0);
            mode = hncd_pkg::MODE_IDLE;
         end else if (mode == hncd_pkg::MODE_DELAY && !ctrl_down && !alt_down && id_acc != 0 &&
                      delay_acc != 0 && !armed) begin
            last_id = id_acc;
            issue(hncd_pkg::ACT_ARM, delay_acc);
            armed = 1;
            mode = hncd_pkg::MODE_IDLE;
         end

         if (mode == hncd_pkg::MODE_IDLE && !ctrl_down && !alt_down) begin
            id_acc = 0;
            delay_acc = 0;
         end
      endfunction

      function void check_command(hncd_pkg::action_type act,
                                  logic [hncd_pkg::TARGET_W-1:0] id,
                                  logic [hncd_pkg::DELAY_W-1:0] dly);
         command_type want;
         if (expected.size() == 0) begin
            $display("%0t: unexpected command: action %0d id %0d delay %0d",
                     $time, act, id, dly);
            errors++;
            return;
         end
         want = expected.pop_front();
         if (act !== want.action) begin
            $display("%0t: action expected %0d actual %0d", $time, want.action, act);
            errors++;
         end
         if (id !== want.target) begin
            $display("%0t: target_id expected %0d actual %0d", $time, want.target, id);
            errors++;
         end
         if (dly !== want.delay) begin
            $display("%0t: delay_ms expected %0d actual %0d", $time, want.delay, dly);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [hncd_pkg::REQ_USER_W-1:0] req_tuser = '0;  // [0] op
   logic [hncd_pkg::REQ_DATA_W-1:0] req_tdata = '0;  // [7:0] scan_byte
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [hncd_pkg::RSP_USER_W-1:0] rsp_tuser;       // [1:0] action
   logic [hncd_pkg::RSP_DATA_W-1:0] rsp_tdata;       // [21:0] target_id, [53:22] delay_ms,
                                                     // zero pad

   command_scoreboard board = new();
   int burst_left = 0;
   int sent_items = 0;
   int idle_cycles = 0;
   int stall_mode = 0;
   int stall_phase = 0;

   hotkey_numeric_command_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // responses are checked before the same edge's request is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            board.check_command(hncd_pkg::action_type'(rsp_tuser),
                                rsp_tdata[hncd_pkg::TARGET_W-1:0],
                                rsp_tdata[hncd_pkg::TARGET_W +: hncd_pkg::DELAY_W]);
         if (req_tvalid && req_tready)
            board.note_request(req_tuser[0], req_tdata);
      end
   end

   // receiver: stall pattern is redrawn whenever the phase counter runs out
   always @(posedge clock) begin
      if (stall_phase == 0) begin
         stall_mode  <= $urandom_range(0, 3);
         stall_phase <= $urandom_range(16, 96);
      end else begin
         stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (stall_phase % 5 == 0);
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("hotkey_numeric_command_decoder_test: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [7:0] key_down(logic [6:0] key);
      return {1'b0, key};
   endfunction

   function automatic logic [7:0] key_up(logic [6:0] key);
      return RELEASE_BIT | {1'b0, key};
   endfunction

   function automatic logic [7:0] digit_key(int value);
      return key_down(value == 0 ? hncd_pkg::KEY_DIG0 : hncd_pkg::KEY_DIG1 + 7'(value - 1));
   endfunction

   // any byte except the Ctrl, Alt and Space keys, so a sequence stays well formed
   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b[6:0] == hncd_pkg::KEY_CTRL || b[6:0] == hncd_pkg::KEY_ALT ||
             b[6:0] == hncd_pkg::KEY_SPACE);
      return b;
   endfunction

   // called right after a rising edge; returns right after the accepting edge
   task automatic send_item(bit op, logic [7:0] scan);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(40, 80) : $urandom_range(1, 20);
         gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid   <= 1'b1;
      req_tuser[0] <= op;
      req_tdata    <= scan;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_items++;
   endtask

   task automatic maybe_noise();
      if ($urandom_range(0, 99) < 15)
         send_item(OP_SCAN, noise_byte());
   endtask

   task automatic send_digits(int count, bit lead_nonzero);
      for (int i = 0; i < count; i++)
         send_item(OP_SCAN, digit_key(i == 0 && lead_nonzero ? $urandom_range(1, 9)
                                                             : $urandom_range(0, 9)));
   endtask

   // Ctrl+Alt, id digits, optional Space with delay groups, release, maybe expiry
   task automatic play_sequence();
      bit ctrl_first;
      int n_id, n_dig, r;
      ctrl_first = $urandom_range(0, 1);
      send_item(OP_SCAN, key_down(ctrl_first ? hncd_pkg::KEY_CTRL : hncd_pkg::KEY_ALT));
      maybe_noise();
      send_item(OP_SCAN, key_down(ctrl_first ? hncd_pkg::KEY_ALT : hncd_pkg::KEY_CTRL));
      r = $urandom_range(0, 9);
      n_id = r == 0 ? 0 : r == 1 ? $urandom_range(7, 9) : $urandom_range(1, 3);
      send_digits(n_id, 1'b1);
      maybe_noise();
      // Space only after a nonzero id, otherwise delay entry never completes
      if (n_id > 0 && $urandom_range(0, 9) < 6) begin
         send_item(OP_SCAN, key_down(hncd_pkg::KEY_SPACE));
         if ($urandom_range(0, 4) == 0)
            send_item(OP_SCAN, key_down(hncd_pkg::KEY_CTRL));
         repeat ($urandom_range(1, 3)) begin
            n_dig = $urandom_range(0, 9) == 0 ? $urandom_range(10, 12) : $urandom_range(1, 3);
            send_digits(n_dig, $urandom_range(0, 3) != 0);
            maybe_noise();
            r = $urandom_range(0, 9);
            if (r < 3)
               send_item(OP_SCAN, key_down(hncd_pkg::KEY_SEC));
            else if (r < 6)
               send_item(OP_SCAN, key_down(hncd_pkg::KEY_MIN));
            else if (r < 9)
               send_item(OP_SCAN, key_down(hncd_pkg::KEY_HOUR));
         end
         send_item(OP_SCAN, key_up(hncd_pkg::KEY_SPACE));
      end
      maybe_noise();
      r = $urandom_range(0, 9);
      if (r != 0)
         send_item(OP_SCAN, key_up(ctrl_first ? hncd_pkg::KEY_CTRL : hncd_pkg::KEY_ALT));
      if (r != 1)
         send_item(OP_SCAN, key_up(ctrl_first ? hncd_pkg::KEY_ALT : hncd_pkg::KEY_CTRL));
      if ($urandom_range(0, 1))
         send_item(OP_EXPIRY, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_item(OP_EXPIRY, 8'hFF);                      // expiry with nothing armed
      send_item(OP_SCAN, 8'h00);                        // unknown keys
      send_item(OP_SCAN, 8'hFF);
      send_item(OP_SCAN, key_down(hncd_pkg::KEY_CTRL)); // release with zero id
      send_item(OP_SCAN, key_down(hncd_pkg::KEY_ALT));
      send_item(OP_SCAN, key_up(hncd_pkg::KEY_CTRL));
      send_item(OP_SCAN, key_up(hncd_pkg::KEY_ALT));
      send_item(OP_SCAN, key_down(hncd_pkg::KEY_CTRL)); // id 901, delay 4h + 2m, 3 pending
      send_item(OP_SCAN, key_down(hncd_pkg::KEY_ALT));
      send_item(OP_SCAN, digit_key(9));
      send_item(OP_SCAN, digit_key(0));
      send_item(OP_SCAN, digit_key(1));
      send_item(OP_SCAN, key_down(hncd_pkg::KEY_SPACE));
      send_item(OP_SCAN, digit_key(4));
      send_item(OP_SCAN, key_down(hncd_pkg::KEY_HOUR));
      send_item(OP_SCAN, digit_key(2));
      send_item(OP_SCAN, key_down(hncd_pkg::KEY_MIN));
      send_item(OP_SCAN, digit_key(3));
      send_item(OP_SCAN, key_up(hncd_pkg::KEY_SPACE));
      send_item(OP_SCAN, key_up(hncd_pkg::KEY_CTRL));
      send_item(OP_SCAN, key_up(hncd_pkg::KEY_ALT));
      send_item(OP_SCAN, key_down(hncd_pkg::KEY_CTRL)); // kill now overwrites the armed target
      send_item(OP_SCAN, key_down(hncd_pkg::KEY_ALT));
      send_item(OP_SCAN, digit_key(7));
      send_item(OP_SCAN, key_up(hncd_pkg::KEY_CTRL));
      send_item(OP_SCAN, key_up(hncd_pkg::KEY_ALT));
      send_item(OP_EXPIRY, 8'h00);

      sent_items = 0;
      while (sent_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0)
            send_item(OP_SCAN, noise_byte());
         play_sequence();
      end
      req_tvalid <= 1'b0;

      while (board.expected.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0)
         $display("hotkey_numeric_command_decoder_test: clean");
      else
         $display("hotkey_numeric_command_decoder_test: errors");
      $finish;
   end

endmodule

// File: hotkey_numeric_command_decoder.f
rtl/hncd_pkg.sv
rtl/hncd_front.sv
rtl/hncd_queue.sv
rtl/hncd_back.sv
rtl/hotkey_numeric_command_decoder.sv
tb/hotkey_numeric_command_decoder_test.sv
